// File: rtl/fdf_pkg.sv
// Shared types, constants and compare functions of the face degenerate filter.
// No dependencies; face_degenerate_filter_core refers to this package by scoped names.
package fdf_pkg;

   localparam int MAX_CORNERS_DEFAULT = 16;
   localparam int RESULT_LIMIT = 16;
   localparam logic [31:0] FILL_RESET = 32'hdeadbeef;

   localparam logic [1:0] CLASS_POINT    = 2'd0;
   localparam logic [1:0] CLASS_LINE     = 2'd1;
   localparam logic [1:0] CLASS_TRIANGLE = 2'd2;
   localparam logic [1:0] CLASS_POLYGON  = 2'd3;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
   } pos_type;

   typedef struct packed {
      logic [31:0] corner_index;
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [31:0] pos_z;
      logic        face_end;
      logic        mesh_end;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] slot_index;
      logic        slot_kept;
      logic        slot_last;
      logic [1:0]  face_class;
      logic        face_degenerate;
      logic        face_overflow;
      logic        mesh_done;
      logic [31:0] mesh_degenerate_count;
      logic [3:0]  mesh_class_mask;
   } rsp_payload_type;

   // IEEE single equality: NaN never matches, +0 matches -0.
   function automatic logic coord_equal(input logic [31:0] a, input logic [31:0] b);
      logic a_nan;
      logic b_nan;
      logic result;
      a_nan = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
      b_nan = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
      if (a_nan || b_nan) begin
         result = 1'b0;
      end else if ((a[30:0] | b[30:0]) == 31'd0) begin
         result = 1'b1;
      end else begin
         result = (a == b);
      end
      return result;
   endfunction

   function automatic logic pos_equal(input pos_type p, input pos_type q);
      return coord_equal(p.x, q.x) && coord_equal(p.y, q.y) && coord_equal(p.z, q.z);
   endfunction

endpackage

// File: rtl/fdf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module fdf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_enable,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_enable) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/face_degenerate_filter_core.sv
// Top level of the face degenerate filter: corner intake, position scan and slot emission.
// Depends on fdf_pkg (types, compare functions) and fdf_ram (kept index and position stores).
//
//  channel  direction  handshake                 payload
//  -------  ---------  ------------------------  ---------------------------------
//  req      in         req_valid / req_stall     req_payload (one face corner)
//  rsp      out        rsp_valid / rsp_stall     rsp_payload (one emitted slot)
//  csr      in         csr_write_enable          csr_write_data (fill word)
//
// A kept corner is accepted, then scanned against the k corners kept so far in its face:
// the position store is read one entry a cycle, and each entry is compared as its read returns.
// A dropped corner ends as soon as it matches; a corner past the limit is only flagged.
// A face end adds a close step, then for each emitted slot an index store read and an output
// load, which waits while rsp_stall holds the output register.
// Reset is synchronous and active high; the stores need no clearing pass.
// rsp_stall only holds the output register; a finished slot waits there while a new
// request is accepted.
module face_degenerate_filter_core #(
   parameter int MAX_CORNERS = fdf_pkg::MAX_CORNERS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  fdf_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output fdf_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_write_enable,
   input  logic [31:0]              csr_write_data
);

   localparam int CNT_W  = $clog2(MAX_CORNERS + 1);
   localparam int ADDR_W = (MAX_CORNERS > 1) ? $clog2(MAX_CORNERS) : 1;
   localparam int POS_W  = $bits(fdf_pkg::pos_type);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CLOSE,
      ST_EMIT
   } state_type;

   // Control state
   state_type   state_ff, state_in;
   logic [CNT_W-1:0] kept_count_ff, kept_count_in;
   logic [CNT_W-1:0] corner_count_ff, corner_count_in;
   logic        overflow_ff, overflow_in;
   logic [31:0] degenerate_total_ff, degenerate_total_in;
   logic [3:0]  class_mask_ff, class_mask_in;
   logic [CNT_W-1:0] scan_ptr_ff, scan_ptr_in;
   logic        cmp_valid_ff, cmp_valid_in;
   logic [CNT_W-1:0] slot_ptr_ff, slot_ptr_in;
   logic [CNT_W-1:0] slot_total_ff, slot_total_in;
   logic        rd_valid_ff, rd_valid_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] fill_word_ff, fill_word_in;

   // Payload registers
   fdf_pkg::req_payload_type corner_ff, corner_in;
   logic [1:0]  face_class_ff, face_class_in;
   logic        face_deg_ff, face_deg_in;
   fdf_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;

   // Store ports
   logic              idx_wr_enable;
   logic [ADDR_W-1:0] wr_addr;
   logic [31:0]       idx_rd_data;
   logic [POS_W-1:0]  pos_rd_data;
   fdf_pkg::pos_type  corner_pos;
   logic              match_now;
   logic              scan_issue;
   logic              req_accept;
   logic              out_free;
   logic              slot_last;
   logic              slot_kept;

   assign corner_pos = '{x: corner_ff.pos_x, y: corner_ff.pos_y, z: corner_ff.pos_z};

   // Kept index and position stores share the write address (the next free slot).
   fdf_ram #(.WIDTH(32), .DEPTH(MAX_CORNERS)) u_idx_ram (
      .clock    (clock),
      .wr_enable(idx_wr_enable),
      .wr_addr  (wr_addr),
      .wr_data  (corner_ff.corner_index),
      .rd_addr  (slot_ptr_ff[ADDR_W-1:0]),
      .rd_data  (idx_rd_data)
   );

   fdf_ram #(.WIDTH(POS_W), .DEPTH(MAX_CORNERS)) u_pos_ram (
      .clock    (clock),
      .wr_enable(idx_wr_enable),
      .wr_addr  (wr_addr),
      .wr_data  (POS_W'(corner_pos)),
      .rd_addr  (scan_ptr_ff[ADDR_W-1:0]),
      .rd_data  (pos_rd_data)
   );

   assign wr_addr    = kept_count_ff[ADDR_W-1:0];
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // Scan: issue one address a cycle, compare the entry read the cycle before.
   // A new entry is written only after the scan ends, so reads never meet a pending write.
   assign scan_issue = (scan_ptr_ff < kept_count_ff);
   assign match_now  = cmp_valid_ff &&
                       fdf_pkg::pos_equal(fdf_pkg::pos_type'(pos_rd_data), corner_pos);

   assign slot_kept = (slot_ptr_ff < kept_count_ff);
   assign slot_last = ((slot_ptr_ff + CNT_W'(1)) == slot_total_ff);

   always_comb begin
      state_in            = state_ff;
      kept_count_in       = kept_count_ff;
      corner_count_in     = corner_count_ff;
      overflow_in         = overflow_ff;
      degenerate_total_in = degenerate_total_ff;
      class_mask_in       = class_mask_ff;
      scan_ptr_in         = scan_ptr_ff;
      cmp_valid_in        = cmp_valid_ff;
      slot_ptr_in         = slot_ptr_ff;
      slot_total_in       = slot_total_ff;
      rd_valid_in         = rd_valid_ff;
      fill_word_in        = csr_write_enable ? csr_write_data : fill_word_ff;
      corner_in           = corner_ff;
      face_class_in       = face_class_ff;
      face_deg_in         = face_deg_ff;
      rsp_payload_in      = rsp_payload_ff;
      idx_wr_enable       = 1'b0;
      // Drop the output once taken; a load below overrides this.
      rsp_valid_in        = rsp_valid_ff && rsp_stall;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               corner_in = req_payload;
               if (32'(corner_count_ff) >= MAX_CORNERS) begin
                  // Corner past the limit: only flag it, but let it close the face.
                  overflow_in = 1'b1;
                  if (req_payload.face_end || req_payload.mesh_end) begin
                     state_in = ST_CLOSE;
                  end
               end else begin
                  scan_ptr_in  = '0;
                  cmp_valid_in = 1'b0;
                  state_in     = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            scan_ptr_in  = scan_issue ? (scan_ptr_ff + CNT_W'(1)) : scan_ptr_ff;
            cmp_valid_in = scan_issue;
            if (match_now || !scan_issue) begin
               if (!match_now) begin
                  idx_wr_enable = 1'b1;
                  kept_count_in = kept_count_ff + CNT_W'(1);
               end
               corner_count_in = corner_count_ff + CNT_W'(1);
               cmp_valid_in    = 1'b0;
               state_in = (corner_ff.face_end || corner_ff.mesh_end) ? ST_CLOSE : ST_IDLE;
            end
         end

         ST_CLOSE: begin
            case (32'(kept_count_ff))
               1:       face_class_in = fdf_pkg::CLASS_POINT;
               2:       face_class_in = fdf_pkg::CLASS_LINE;
               3:       face_class_in = fdf_pkg::CLASS_TRIANGLE;
               default: face_class_in = fdf_pkg::CLASS_POLYGON;
            endcase
            face_deg_in = (kept_count_ff < corner_count_ff);
            if (face_deg_in && (degenerate_total_ff != 32'hffffffff)) begin
               degenerate_total_in = degenerate_total_ff + 32'd1;
            end
            class_mask_in = class_mask_ff | (4'b0001 << face_class_in);
            slot_total_in = (32'(corner_count_ff) > fdf_pkg::RESULT_LIMIT)
                            ? CNT_W'(fdf_pkg::RESULT_LIMIT) : corner_count_ff;
            slot_ptr_in   = '0;
            rd_valid_in   = 1'b0;
            state_in      = ST_EMIT;
         end

         ST_EMIT: begin
            // Index store data matches slot_ptr in the cycle after the pointer settles.
            rd_valid_in = 1'b1;
            if (rd_valid_ff && out_free) begin
               rsp_valid_in = 1'b1;
               rsp_payload_in.slot_index      = slot_kept ? idx_rd_data : fill_word_ff;
               rsp_payload_in.slot_kept       = slot_kept;
               rsp_payload_in.slot_last       = slot_last;
               rsp_payload_in.face_class      = face_class_ff;
               rsp_payload_in.face_degenerate = face_deg_ff;
               rsp_payload_in.face_overflow   = overflow_ff;
               rsp_payload_in.mesh_done       = corner_ff.mesh_end;
               rsp_payload_in.mesh_degenerate_count =
                  corner_ff.mesh_end ? degenerate_total_ff : 32'd0;
               rsp_payload_in.mesh_class_mask = corner_ff.mesh_end ? class_mask_ff : 4'd0;
               slot_ptr_in = slot_ptr_ff + CNT_W'(1);
               rd_valid_in = 1'b0;
               if (slot_last) begin
                  // Face done: clear face state, and mesh totals on a mesh end.
                  kept_count_in   = '0;
                  corner_count_in = '0;
                  overflow_in     = 1'b0;
                  if (corner_ff.mesh_end) begin
                     degenerate_total_in = '0;
                     class_mask_in       = '0;
                  end
                  state_in = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff            <= ST_IDLE;
         kept_count_ff       <= '0;
         corner_count_ff     <= '0;
         overflow_ff         <= 1'b0;
         degenerate_total_ff <= '0;
         class_mask_ff       <= '0;
         scan_ptr_ff         <= '0;
         cmp_valid_ff        <= 1'b0;
         slot_ptr_ff         <= '0;
         slot_total_ff       <= '0;
         rd_valid_ff         <= 1'b0;
         rsp_valid_ff        <= 1'b0;
         fill_word_ff        <= fdf_pkg::FILL_RESET;
      end else begin
         state_ff            <= state_in;
         kept_count_ff       <= kept_count_in;
         corner_count_ff     <= corner_count_in;
         overflow_ff         <= overflow_in;
         degenerate_total_ff <= degenerate_total_in;
         class_mask_ff       <= class_mask_in;
         scan_ptr_ff         <= scan_ptr_in;
         cmp_valid_ff        <= cmp_valid_in;
         slot_ptr_ff         <= slot_ptr_in;
         slot_total_ff       <= slot_total_in;
         rd_valid_ff         <= rd_valid_in;
         rsp_valid_ff        <= rsp_valid_in;
         fill_word_ff        <= fill_word_in;
      end
      corner_ff      <= corner_in;
      face_class_ff  <= face_class_in;
      face_deg_ff    <= face_deg_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // Kept corners are a subset of accepted corners.
   a_kept_le_corners: assert property (@(posedge clock) disable iff (reset)
      kept_count_ff <= corner_count_ff)
      else $error("kept count exceeds corner count");

   // Accepted corners never pass the limit.
   a_corner_limit: assert property (@(posedge clock) disable iff (reset)
      32'(corner_count_ff) <= MAX_CORNERS)
      else $error("corner count past limit");

   // An overflow flag only exists on a full face.
   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      overflow_ff |-> (32'(corner_count_ff) == MAX_CORNERS))
      else $error("overflow flagged on a face below the limit");

   // Loading the last slot of a face returns to idle with the face state cleared.
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && rd_valid_ff && out_free && slot_last) |=>
      (state_ff == ST_IDLE && kept_count_ff == '0 && corner_count_ff == '0
       && rsp_valid_ff && rsp_payload_ff.slot_last))
      else $error("face state not cleared after last slot");

endmodule
